@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the irc parameter parser rtl
// expects a clock named clk and an active-high reset named rst in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/ircp_pkg.sv @@
// package for the irc parameter parser: result type, mode and kind codes, octet classes
// no dependencies
package ircp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned OUT_LEN_W = 10;
  localparam int unsigned MODE_W  = 3;

  // parse modes
  localparam logic [MODE_W-1:0] MODE_LEAD        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AFTER_SPACE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIDDLE      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRAIL       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DONE        = 3'd4;

  // byte kinds
  localparam logic [KIND_W-1:0] KIND_SEP     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CONTENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COLON   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

  // special octets
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3a;

  // middle count saturates here
  localparam logic [INDEX_W-1:0] COUNT_MAX = 4'hf;

  typedef struct packed {
    logic [BYTE_W-1:0]    byte_val;
    logic [INDEX_W-1:0]   field_index;
    logic [KIND_W-1:0]    byte_kind;
    logic [OUT_LEN_W-1:0] consumed_length;
    logic                 end_of_message;
  } ircp_result_t;

  // any octet except nul, cr, lf, space and colon
  function automatic logic is_legal(input logic [BYTE_W-1:0] c);
    return c inside {[8'h01:8'h09], [8'h0b:8'h0c], [8'h0e:8'h1f],
                     [8'h21:8'h39], [8'h3b:8'hff]};
  endfunction

  // octets allowed in the trailing parameter
  function automatic logic is_trail(input logic [BYTE_W-1:0] c);
    return is_legal(c) || (c == CHAR_COLON) || (c == CHAR_SPACE);
  endfunction

endpackage

@@ rtl/core/ircp_in_stage.sv @@
// input register of the irc parameter parser
// depends on ircp_pkg
module ircp_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ircp_pkg::BYTE_W-1:0] data_byte,
  input  logic                      message_end,
  input  logic                      advance,
  output logic                      held_valid,
  output logic [ircp_pkg::BYTE_W-1:0] held_byte,
  output logic                      held_end
);
  import ircp_pkg::*;

  // room when empty or when the held item moves on this cycle
  assign in_ready = !held_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= data_byte;
      held_end  <= message_end;
    end
  end

endmodule

@@ rtl/core/ircp_tagger.sv @@
// parse state and per-byte classification of the irc parameter parser
// depends on ircp_pkg and assert_macros.svh
module ircp_tagger #(
  parameter int unsigned MAX_MIDDLE = 14,
  parameter int unsigned LEN_WIDTH  = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [ircp_pkg::BYTE_W-1:0] byte_in,
  input  logic                      end_in,
  output ircp_pkg::ircp_result_t    result
);
  import ircp_pkg::*;

  localparam logic [INDEX_W-1:0]   MaxMid = INDEX_W'(MAX_MIDDLE);
  localparam logic [LEN_WIDTH-1:0] LenMax = {LEN_WIDTH{1'b1}};

  logic [MODE_W-1:0]    mode, mode_next;
  logic [INDEX_W-1:0]   middle_count, middle_count_next;
  logic [LEN_WIDTH-1:0] length_count, length_next;
  logic [KIND_W-1:0]    kind;
  logic                 close_mid;
  logic                 at_lead;
  logic [MODE_W-1:0]    lead_mode;
  logic [KIND_W-1:0]    lead_kind;

  // a byte seen where a new parameter may start
  assign lead_mode = (byte_in == CHAR_SPACE) ? MODE_AFTER_SPACE : MODE_DONE;
  assign lead_kind = (byte_in == CHAR_SPACE) ? KIND_SEP : KIND_NONE;

  // mode transitions and byte kind
  always_comb begin
    close_mid = 1'b0;
    at_lead   = 1'b0;
    mode_next = mode;
    kind      = KIND_NONE;
    case (mode)
      MODE_LEAD: begin
        at_lead = 1'b1;
      end
      MODE_AFTER_SPACE: begin
        if (byte_in == CHAR_COLON) begin
          mode_next = MODE_TRAIL;
          kind      = KIND_COLON;
        end else if (middle_count < MaxMid) begin
          if (is_legal(byte_in)) begin
            mode_next = MODE_MIDDLE;
            kind      = KIND_CONTENT;
          end else begin
            close_mid = 1'b1;
            at_lead   = 1'b1;
          end
        end else if (is_trail(byte_in)) begin
          mode_next = MODE_TRAIL;
          kind      = KIND_CONTENT;
        end else begin
          mode_next = MODE_DONE;
        end
      end
      MODE_MIDDLE: begin
        if (is_legal(byte_in) || byte_in == CHAR_COLON) begin
          kind = KIND_CONTENT;
        end else begin
          close_mid = 1'b1;
          at_lead   = 1'b1;
        end
      end
      MODE_TRAIL: begin
        if (is_trail(byte_in)) begin
          kind = KIND_CONTENT;
        end else begin
          mode_next = MODE_DONE;
        end
      end
      default: begin
        mode_next = MODE_DONE;
      end
    endcase
    if (at_lead) begin
      mode_next = lead_mode;
      kind      = lead_kind;
    end
  end

  // middle count saturates, length saturates
  assign middle_count_next = (close_mid && middle_count != COUNT_MAX) ?
                             middle_count + 1'b1 : middle_count;
  assign length_next = (kind != KIND_NONE && length_count != LenMax) ?
                       length_count + 1'b1 : length_count;

  // result of the current byte
  always_comb begin
    result.byte_val        = byte_in;
    result.field_index     = (kind == KIND_NONE) ? '0 : middle_count_next;
    result.byte_kind       = kind;
    result.consumed_length = OUT_LEN_W'(length_next);
    result.end_of_message  = end_in;
  end

  // state registers, cleared after the last byte of a message
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_LEAD;
      middle_count <= '0;
      length_count <= '0;
    end else if (step) begin
      if (end_in) begin
        mode         <= MODE_LEAD;
        middle_count <= '0;
        length_count <= '0;
      end else begin
        mode         <= mode_next;
        middle_count <= middle_count_next;
        length_count <= length_next;
      end
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_end_clears, step && end_in |=> mode == MODE_LEAD && length_count == '0, "state not cleared after message end")
  `ASSERT_CLK(a_done_sticks, step && !end_in && mode == MODE_DONE |=> mode == MODE_DONE, "stopped parse resumed")
  `ASSERT_CLK(a_len_grows, step && !end_in |=> length_count >= $past(length_count), "length went backward")
  `ASSERT_ALWAYS(a_hold_idle, !rst && !$past(step) && !$past(rst) |-> $stable(mode) && $stable(length_count), "state moved without a byte")

endmodule

@@ rtl/core/ircp_out_stage.sv @@
// result register of the irc parameter parser
// depends on ircp_pkg
module ircp_out_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load_valid,
  input  ircp_pkg::ircp_result_t  load_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    advance,
  output ircp_pkg::ircp_result_t  data
);
  import ircp_pkg::*;

  // register may load when empty or being drained
  assign advance = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      data <= load_data;
    end
  end

endmodule

@@ rtl/core/irc_params_byte_parser.sv @@
// Tags each byte of an irc message parameter section as field separator, content, trailing
// colon or not consumed, one byte per clock while the output is not stalled by out_ready. An
// accepted byte passes an input register and then its tag is loaded into the result register,
// which drives out_valid; a byte can be accepted while the previous one is still in flight. The
// parse mode, middle count and length counter are updated as a byte moves into the result
// register. in_ready stays high while the result register is empty or being taken. State
// returns to its reset values after a byte with message_end set.
// depends on ircp_pkg, ircp_in_stage, ircp_tagger, ircp_out_stage
module irc_params_byte_parser #(
  parameter int unsigned MAX_MIDDLE = 14,
  parameter int unsigned LEN_WIDTH  = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ircp_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           message_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ircp_pkg::BYTE_W-1:0]    byte_out,
  output logic [ircp_pkg::INDEX_W-1:0]   field_index,
  output logic [ircp_pkg::KIND_W-1:0]    byte_kind,
  output logic [ircp_pkg::OUT_LEN_W-1:0] consumed_length,
  output logic                           end_of_message
);
  import ircp_pkg::*;

  logic                held_valid;
  logic [BYTE_W-1:0]   held_byte;
  logic                held_end;
  logic                advance;
  ircp_result_t        tag;
  ircp_result_t        res;

  // input register
  ircp_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .message_end (message_end),
    .advance     (advance),
    .held_valid  (held_valid),
    .held_byte   (held_byte),
    .held_end    (held_end)
  );

  // classification and parse state
  ircp_tagger #(
    .MAX_MIDDLE (MAX_MIDDLE),
    .LEN_WIDTH  (LEN_WIDTH)
  ) u_tag (
    .clk     (clk),
    .rst     (rst),
    .step    (held_valid && advance),
    .byte_in (held_byte),
    .end_in  (held_end),
    .result  (tag)
  );

  // result register
  ircp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .load_data  (tag),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .advance    (advance),
    .data       (res)
  );

  assign byte_out        = res.byte_val;
  assign field_index     = res.field_index;
  assign byte_kind       = res.byte_kind;
  assign consumed_length = res.consumed_length;
  assign end_of_message  = res.end_of_message;

endmodule

@@ bench/tb_irc_params_byte_parser.sv @@
// testbench for irc_params_byte_parser: directed and random irc parameter sections,
// each tag checked against a byte-level parse mode tracker kept in the bench
// depends on ircp_pkg and the irc_params_byte_parser rtl
`timescale 1ns / 100ps

module tb_irc_params_byte_parser;
  import ircp_pkg::*;

  localparam int unsigned MID_LIMIT = 14;
  localparam logic [OUT_LEN_W-1:0] LEN_TOP = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 message_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    byte_out;
  logic [INDEX_W-1:0]   field_index;
  logic [KIND_W-1:0]    byte_kind;
  logic [OUT_LEN_W-1:0] consumed_length;
  logic                 end_of_message;

  // parse tracker state
  logic [MODE_W-1:0]    tag_mode = MODE_LEAD;
  logic [INDEX_W-1:0]   closed_mids = '0;
  logic [OUT_LEN_W-1:0] len_seen = '0;

  ircp_result_t      tag_q[$];
  logic [BYTE_W-1:0] msg_q[$];
  int                mismatch_count = 0;
  int                burst_left = 0;
  int                rx_cycle = 0;
  int                rx_style = 0;

  irc_params_byte_parser #(
    .MAX_MIDDLE(MID_LIMIT),
    .LEN_WIDTH (OUT_LEN_W)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .message_end    (message_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_out       (byte_out),
    .field_index    (field_index),
    .byte_kind      (byte_kind),
    .consumed_length(consumed_length),
    .end_of_message (end_of_message)
  );

  always #5 clk = ~clk;

  // octet classes
  function automatic logic octet_ok(input logic [BYTE_W-1:0] c);
    return (c != 8'h00) && (c != 8'h0a) && (c != 8'h0d) &&
           (c != CHAR_SPACE) && (c != CHAR_COLON);
  endfunction

  function automatic logic octet_trail(input logic [BYTE_W-1:0] c);
    return octet_ok(c) || (c == CHAR_SPACE) || (c == CHAR_COLON);
  endfunction

  // octet seen where a new parameter may start
  function automatic logic [KIND_W-1:0] open_or_stop(input logic [BYTE_W-1:0] c);
    if (c == CHAR_SPACE) begin
      tag_mode = MODE_AFTER_SPACE;
      return KIND_SEP;
    end
    tag_mode = MODE_DONE;
    return KIND_NONE;
  endfunction

  // advance the tracker by one byte and queue the tag it should get
  task automatic record_tag(input logic [BYTE_W-1:0] b, input logic e);
    logic [KIND_W-1:0] kind;
    ircp_result_t      r;
    case (tag_mode)
      MODE_LEAD: begin
        kind = open_or_stop(b);
      end
      MODE_AFTER_SPACE: begin
        if (b == CHAR_COLON) begin
          tag_mode = MODE_TRAIL;
          kind = KIND_COLON;
        end else if (closed_mids < MID_LIMIT) begin
          if (octet_ok(b)) begin
            tag_mode = MODE_MIDDLE;
            kind = KIND_CONTENT;
          end else begin
            // empty parameter still counts
            if (closed_mids != COUNT_MAX) closed_mids = closed_mids + 1'b1;
            kind = open_or_stop(b);
          end
        end else if (octet_trail(b)) begin
          // last field opened without a colon
          tag_mode = MODE_TRAIL;
          kind = KIND_CONTENT;
        end else begin
          tag_mode = MODE_DONE;
          kind = KIND_NONE;
        end
      end
      MODE_MIDDLE: begin
        if (octet_ok(b) || b == CHAR_COLON) begin
          kind = KIND_CONTENT;
        end else begin
          if (closed_mids != COUNT_MAX) closed_mids = closed_mids + 1'b1;
          kind = open_or_stop(b);
        end
      end
      MODE_TRAIL: begin
        if (octet_trail(b)) begin
          kind = KIND_CONTENT;
        end else begin
          tag_mode = MODE_DONE;
          kind = KIND_NONE;
        end
      end
      default: begin
        tag_mode = MODE_DONE;
        kind = KIND_NONE;
      end
    endcase
    if (kind != KIND_NONE && len_seen != LEN_TOP) len_seen = len_seen + 1'b1;
    r.byte_val        = b;
    r.field_index     = (kind == KIND_NONE) ? '0 : closed_mids;
    r.byte_kind       = kind;
    r.consumed_length = len_seen;
    r.end_of_message  = e;
    tag_q.push_back(r);
    if (e) begin
      tag_mode    = MODE_LEAD;
      closed_mids = '0;
      len_seen    = '0;
    end
  endtask

  // drive one item, with bursts and gaps on the sending side
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    data_byte   <= b;
    message_end <= e;
    burst_left--;
    do @(posedge clk); while (!in_ready);
    record_tag(b, e);
  endtask

  // send the queued message, end flag on its last byte
  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  // hold off the sender until every tag has come back
  task automatic drain_tags();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (tag_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] any_legal();
    logic [BYTE_W-1:0] c;
    c = 8'($urandom_range(1, 255));
    while (!octet_ok(c)) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] any_trail();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return CHAR_SPACE;
    if (pick == 1) return CHAR_COLON;
    return any_legal();
  endfunction

  // first byte not a space stops the parse at once
  task automatic test_stop_without_space();
    msg_q.push_back(8'hff);
    msg_q.push_back(CHAR_SPACE);
    send_msg();
  endtask

  // a middle with a colon inside, then trailing with spaces and colons
  task automatic test_middles_and_trailing();
    push_str(" a:b");
    msg_q.push_back(8'hff);
    push_str(" :x :y");
    send_msg();
  endtask

  // double space opens an empty parameter; bad octet after a space stops
  task automatic test_empty_params();
    push_str("  a");
    msg_q.push_back(8'h00);
    msg_q.push_back(8'h01);
    send_msg();
    msg_q.push_back(CHAR_SPACE);
    msg_q.push_back(8'h0d);
    send_msg();
  endtask

  // message ending right after the opening space, then a fresh one
  task automatic test_end_after_space();
    push_str(" ");
    send_msg();
    push_str(" q");
    send_msg();
  endtask

  // fourteen middles: next field is trailing without a colon, or a bad octet stops the parse
  task automatic test_fourteen_middles();
    for (int k = 0; k < MID_LIMIT; k++) begin
      msg_q.push_back(CHAR_SPACE);
      msg_q.push_back(any_legal());
    end
    push_str(" t :x");
    send_msg();
    for (int k = 0; k < MID_LIMIT; k++) begin
      msg_q.push_back(CHAR_SPACE);
      msg_q.push_back(any_legal());
    end
    msg_q.push_back(CHAR_SPACE);
    msg_q.push_back(8'h0a);
    msg_q.push_back(8'h7a);
    send_msg();
  endtask

  // mostly well-formed sections, some corrupted, some plain noise
  task automatic build_random_msg();
    int style;
    int n_mid;
    int n_len;
    int pos;
    style = $urandom_range(0, 9);
    if (style == 9) begin
      n_len = $urandom_range(1, 8);
      for (int k = 0; k < n_len; k++) begin
        if ($urandom_range(0, 3) == 0) msg_q.push_back(CHAR_SPACE);
        else msg_q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      msg_q.push_back(CHAR_SPACE);
      n_mid = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 4);
      for (int k = 0; k < n_mid; k++) begin
        if (k > 0) msg_q.push_back(CHAR_SPACE);
        if ($urandom_range(0, 9) != 0) begin
          msg_q.push_back(any_legal());
          n_len = $urandom_range(0, 4);
          for (int j = 0; j < n_len; j++)
            msg_q.push_back(($urandom_range(0, 4) == 0) ? CHAR_COLON : any_legal());
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        if (n_mid > 0) msg_q.push_back(CHAR_SPACE);
        if (n_mid < MID_LIMIT || $urandom_range(0, 1) == 1) msg_q.push_back(CHAR_COLON);
        n_len = $urandom_range(0, 8);
        for (int j = 0; j < n_len; j++) msg_q.push_back(any_trail());
      end
      // broken section: a bad octet somewhere, maybe junk after it
      if (style >= 7) begin
        pos = $urandom_range(0, msg_q.size() - 1);
        case ($urandom_range(0, 3))
          0: msg_q[pos] = 8'h00;
          1: msg_q[pos] = 8'h0a;
          2: msg_q[pos] = 8'h0d;
          default: msg_q[pos] = 8'($urandom_range(0, 255));
        endcase
        n_len = $urandom_range(0, 3);
        for (int j = 0; j < n_len; j++) msg_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random_messages();
    int sent;
    sent = 0;
    while (sent < 310) begin
      build_random_msg();
      sent += msg_q.size();
      send_msg();
      if ($urandom_range(0, 15) == 0) drain_tags();
    end
  endtask

  // receiver stall pattern, with a style picked at random from four
  always @(negedge clk) begin
    if (rx_cycle % 48 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cycle % 4 == 0);
      default: out_ready <= ((rx_cycle % 16) >= 8);
    endcase
    rx_cycle++;
  end

  task automatic report(input logic have_exp, input ircp_result_t want, input ircp_result_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (!have_exp)
        $display("unexpected item: byte %h idx %0d kind %0d len %0d end %0d",
                 seen.byte_val, seen.field_index, seen.byte_kind, seen.consumed_length,
                 seen.end_of_message);
      else
        $display("mismatch: byte %h/%h idx %0d/%0d kind %0d/%0d len %0d/%0d end %0d/%0d",
                 want.byte_val, seen.byte_val, want.field_index, seen.field_index,
                 want.byte_kind, seen.byte_kind, want.consumed_length, seen.consumed_length,
                 want.end_of_message, seen.end_of_message);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    ircp_result_t seen;
    ircp_result_t want;
    if (!rst && out_valid && out_ready) begin
      seen = {byte_out, field_index, byte_kind, consumed_length, end_of_message};
      if (tag_q.size() == 0) begin
        want = '0;
        report(1'b0, want, seen);
      end else begin
        want = tag_q.pop_front();
        if (seen !== want) report(1'b1, want, seen);
      end
    end
  end

  // main sequence
  initial begin
    int waited;
    waited = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_stop_without_space();
    test_middles_and_trailing();
    test_empty_params();
    test_end_after_space();
    drain_tags();
    test_fourteen_middles();
    test_random_messages();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tag_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    mismatch_count += tag_q.size();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
